@@ rtl/tpq_pkg.sv @@
// Shared types and constants for the tree path min/max edge query block.
package tpq_pkg;

	localparam int MaxNodesDefault   = 1024;
	localparam int LiftLevelsDefault = 10;
	localparam int WEIGHT_BITS       = 20;
	localparam int FIELD_NODE_BITS   = 10;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]                 opcode;
		logic [FIELD_NODE_BITS-1:0] node_a;
		logic [FIELD_NODE_BITS-1:0] node_b;
		logic [FIELD_NODE_BITS-1:0] node_depth;
		logic [WEIGHT_BITS-1:0]     edge_weight;
	} req_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] path_min;
		logic [WEIGHT_BITS-1:0] path_max;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_B_RJ, ST_B_RM, ST_B_WR,
		ST_Q_DA, ST_Q_DB, ST_Q_CMP,
		ST_LIFT, ST_LIFT_W, ST_CHECK,
		ST_D_RA, ST_D_RB, ST_D_C,
		ST_F_RA, ST_F_RB, ST_F_C, ST_DONE
	} state_t;

endpackage

@@ rtl/tree_path_min_max_edge_query.sv @@
// Top level: binary lifting path min/max edge query with one shared table port.
// A load writes its level-0 record and depth on accept; a build reads two entries and writes
// one per node per level above 0; a query reads both depths, lifts the deeper endpoint, then
// walks the levels down, one table read at a time through the single jump-table port.
// Throughput: one transaction at a time; req_stall is high while a build or query runs
// and while a finished result waits on rsp_stall. Reset: arst_n clears control and sets
// node_count to 1; tables stay undefined until loaded.
module tree_path_min_max_edge_query
	import tpq_pkg::*;
#(
	parameter int MAX_NODES   = MaxNodesDefault,
	parameter int LIFT_LEVELS = LiftLevelsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] cfg_data
);
	localparam int NB = $clog2(MAX_NODES);
	localparam int LB = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int KW = $clog2(LIFT_LEVELS + 1);
	localparam int AW = LB + NB;
	localparam int EW = NB + 2 * WEIGHT_BITS;
	localparam logic [WEIGHT_BITS-1:0] W_ONES = '1;

	state_t state_q, state_d;

	logic [9:0]             node_count_q;
	logic [NB-1:0]          a_q, b_q, j_q, last_q;
	logic [KW-1:0]          lvl_q;
	logic [9:0]             da_q, diff_q;
	logic [WEIGHT_BITS-1:0] lo_q, hi_q;
	logic [EW-1:0]          ea_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	// jump table port: entry = {ancestor, max, min}
	logic          tab_we;
	logic [AW-1:0] tab_waddr, tab_raddr;
	logic [EW-1:0] tab_wdata, tab_rdata_raw, tab_rdata;
	logic [NB-1:0] tab_rnode;
	logic          tab_rzero_q;

	logic          dep_we;
	logic [NB-1:0] dep_raddr;
	logic [9:0]    dep_rdata_raw, dep_rdata;
	logic          dep_rzero_q;

	logic          req_acc;
	logic [NB-1:0] in_a, in_b, last_d;

	logic [NB-1:0]          e_anc, ea_anc;
	logic [WEIGHT_BITS-1:0] e_max, e_min, ea_max, ea_min;

	// Out-of-range node numbers fold to node 0, the null node above the root.
	assign in_a = (32'(req.node_a) < MAX_NODES) ? NB'(req.node_a) : '0;
	assign in_b = (32'(req.node_b) < MAX_NODES) ? NB'(req.node_b) : '0;
	assign last_d = (32'(node_count_q) > MAX_NODES - 1) ? NB'(MAX_NODES - 1)
	                                                    : NB'(node_count_q);

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Node 0 reads as all-zero in every table.
	assign tab_rdata = tab_rzero_q ? '0 : tab_rdata_raw;
	assign dep_rdata = dep_rzero_q ? '0 : dep_rdata_raw;
	assign {e_anc, e_max, e_min}    = tab_rdata;
	assign {ea_anc, ea_max, ea_min} = ea_q;

	tpq_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_tab (
		.clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
		.raddr(tab_raddr), .rdata(tab_rdata_raw)
	);

	tpq_ram #(.WIDTH(10), .DEPTH(2 ** NB)) u_dep (
		.clk(clk), .we(dep_we), .waddr(in_a), .wdata(req.node_depth),
		.raddr(dep_raddr), .rdata(dep_rdata_raw)
	);

	// Read address selection: which node and level the shared port serves this cycle.
	always_comb begin
		tab_rnode = a_q;
		tab_raddr = {LB'(lvl_q), a_q};
		dep_raddr = a_q;
		case (state_q)
			ST_B_RJ: begin
				tab_rnode = j_q;
				tab_raddr = {LB'(lvl_q - KW'(1)), j_q};
			end
			ST_B_RM: begin
				tab_rnode = e_anc;
				tab_raddr = {LB'(lvl_q - KW'(1)), e_anc};
			end
			ST_D_RB: begin
				tab_rnode = b_q;
				tab_raddr = {LB'(lvl_q), b_q};
			end
			ST_F_RA: begin
				tab_raddr = {LB'(0), a_q};
			end
			ST_F_RB: begin
				tab_rnode = b_q;
				tab_raddr = {LB'(0), b_q};
			end
			ST_Q_DB: dep_raddr = b_q;
			default: ;
		endcase
	end

	// Write port: level-0 records on load, upper levels during build.
	always_comb begin
		tab_we    = 1'b0;
		dep_we    = 1'b0;
		tab_waddr = {LB'(0), in_a};
		tab_wdata = {in_b, req.edge_weight, req.edge_weight};
		if (state_q == ST_IDLE && req_acc && req.opcode == OP_LOAD && in_a != '0) begin
			tab_we = 1'b1;
			dep_we = 1'b1;
		end else if (state_q == ST_B_WR) begin
			tab_we    = 1'b1;
			tab_waddr = {LB'(lvl_q), j_q};
			tab_wdata = {e_anc, (ea_max > e_max) ? ea_max : e_max,
			             (ea_min < e_min) ? ea_min : e_min};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc && req.opcode == OP_BUILD && last_d != '0 && LIFT_LEVELS > 1) begin
					state_d = ST_B_RJ;
				end else if (req_acc && req.opcode == OP_QUERY) begin
					state_d = ST_Q_DA;
				end
			end
			ST_B_RJ:  state_d = ST_B_RM;
			ST_B_RM:  state_d = ST_B_WR;
			ST_B_WR: begin
				if (j_q == last_q && 32'(lvl_q) == LIFT_LEVELS - 1) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_B_RJ;
				end
			end
			ST_Q_DA:  state_d = ST_Q_DB;
			ST_Q_DB:  state_d = ST_Q_CMP;
			ST_Q_CMP: state_d = ST_LIFT;
			ST_LIFT: begin
				if (32'(lvl_q) == LIFT_LEVELS) begin
					state_d = ST_CHECK;
				end else if (((diff_q >> lvl_q) & 10'd1) != '0) begin
					state_d = ST_LIFT_W;
				end
			end
			ST_LIFT_W: state_d = ST_LIFT;
			ST_CHECK:  state_d = (a_q == b_q) ? ST_DONE : ST_D_RA;
			ST_D_RA:   state_d = ST_D_RB;
			ST_D_RB:   state_d = ST_D_C;
			ST_D_C:    state_d = (lvl_q == '0) ? ST_F_RA : ST_D_RA;
			ST_F_RA:   state_d = (a_q == b_q) ? ST_DONE : ST_F_RB;
			ST_F_RB:   state_d = ST_F_C;
			ST_F_C:    state_d = ST_DONE;
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= 10'd1;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		tab_rzero_q <= (tab_rnode == '0);
		dep_rzero_q <= (dep_raddr == '0);
		case (state_q)
			ST_IDLE: begin
				a_q    <= in_a;
				b_q    <= in_b;
				last_q <= last_d;
				lvl_q  <= KW'(1);
				j_q    <= NB'(1);
				lo_q   <= W_ONES;
				hi_q   <= '0;
			end
			ST_B_RM: ea_q <= tab_rdata;
			ST_B_WR: begin
				if (j_q == last_q) begin
					j_q   <= NB'(1);
					lvl_q <= lvl_q + KW'(1);
				end else begin
					j_q <= j_q + NB'(1);
				end
			end
			ST_Q_DB: da_q <= dep_rdata;
			ST_Q_CMP: begin
				// Lift from the deeper endpoint; swap so a is deeper.
				lvl_q <= '0;
				if (da_q < dep_rdata) begin
					a_q    <= b_q;
					b_q    <= a_q;
					diff_q <= dep_rdata - da_q;
				end else begin
					diff_q <= da_q - dep_rdata;
				end
			end
			ST_LIFT: begin
				if (32'(lvl_q) != LIFT_LEVELS && ((diff_q >> lvl_q) & 10'd1) == '0) begin
					lvl_q <= lvl_q + KW'(1);
				end
			end
			ST_LIFT_W: begin
				hi_q  <= (e_max > hi_q) ? e_max : hi_q;
				lo_q  <= (e_min < lo_q) ? e_min : lo_q;
				a_q   <= e_anc;
				lvl_q <= lvl_q + KW'(1);
			end
			ST_CHECK: lvl_q <= KW'(LIFT_LEVELS - 1);
			ST_D_RB:  ea_q <= tab_rdata;
			ST_D_C: begin
				if (ea_anc != e_anc) begin
					hi_q <= (ea_max > hi_q && ea_max >= e_max) ? ea_max
					      : (e_max > hi_q) ? e_max : hi_q;
					lo_q <= (ea_min < lo_q && ea_min <= e_min) ? ea_min
					      : (e_min < lo_q) ? e_min : lo_q;
					a_q  <= ea_anc;
					b_q  <= e_anc;
				end
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - KW'(1);
				end
			end
			ST_F_RB: ea_q <= tab_rdata;
			ST_F_C: begin
				hi_q <= (ea_max > hi_q && ea_max >= e_max) ? ea_max
				      : (e_max > hi_q) ? e_max : hi_q;
				lo_q <= (ea_min < lo_q && ea_min <= e_min) ? ea_min
				      : (e_min < lo_q) ? e_min : lo_q;
			end
			default: ;
		endcase
		if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.path_min <= lo_q;
			rsp_q.path_max <= hi_q;
		end
	end
endmodule

@@ rtl/tpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/tpq_checker.sv @@
// Port-level checker for the tree path query block, bound to the top level.
module tpq_checker
	import tpq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);
	// Hold a stalled result transaction.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// A query occupies the block the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.opcode == OP_QUERY |=> req_stall)
		else $error("query accepted but block not busy");

	// A new result only follows busy work.
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without work");

	// A load leaves the block free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.opcode == OP_LOAD |=> !req_stall)
		else $error("load stalled the block");
endmodule

bind tree_path_min_max_edge_query tpq_checker u_tpq_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
	.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
